@@ rtl/core/bscf_pkg.sv @@
package bscf_pkg;

	localparam int IDX_W = 7;
	localparam int BIT_W = 13;
	localparam int ANS_W = 11;
	localparam logic [ANS_W-1:0] ANS_MAX = 11'h7FF;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef enum logic [3:0] {
		REQ_SET        = 4'd0,
		REQ_CLEAR      = 4'd1,
		REQ_GET        = 4'd2,
		REQ_SET_ALL    = 4'd3,
		REQ_CLEAR_ALL  = 4'd4,
		REQ_INVERT     = 4'd5,
		REQ_COUNT      = 4'd6,
		REQ_ALL_SET    = 4'd7,
		REQ_ALL_CLEAR  = 4'd8,
		REQ_ANY_SET    = 4'd9,
		REQ_FIND_SET   = 4'd10,
		REQ_FIND_CLEAR = 4'd11
	} req_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_REM,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [9:0]  position;
		logic [10:0] window_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ANS_W-1:0] answer;
	} out_item_t;

	typedef struct packed {
		logic             write;
		logic             bit_val;
		logic             found;
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] ones;
		logic             is_ones;
		logic             is_zero;
	} word_flags_t;

endpackage

@@ rtl/core/bitmap_set_clear_count_find.sv @@
// Bitmap engine holding NUM_WORDS words of WORD_BITS bits, of which words_in_use are active.
// Requests arrive on in_valid/in_ready with in_data and each transaction gives exactly
// one result on out_valid/out_ready with out_data (status and answer).
// The words_in_use register is written through cfg_wen/cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce. Every request passes a
// word index calculation state (S_DIV) and a remainder and range checking state (S_REM);
// unless a single-bit or find position is out of range or the code is unused, one word of
// the array is then read per cycle from a single-port-read RAM and passed through a shared
// word unit that modifies, counts, tests or searches it. Single-bit requests read one word,
// whole-array, count and test ones all active words, a find up to a match or its window end.
// One request is in flight at a time; in_ready is high only while the engine is idle.
// The result is held in an output register, so a new request is accepted while the
// previous result is still waiting; a stalled receiver holds the engine in its final
// cycle until the output register is free.
// After reset the array is cleared by a pass over all NUM_WORDS words, one word per cycle,
// during which in_ready stays low; configuration writes are accepted throughout.
module bitmap_set_clear_count_find #(
	parameter int WORD_BITS = 32,
	parameter int NUM_WORDS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bscf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bscf_pkg::out_item_t out_data,
	input  logic                cfg_wen,
	input  logic [5:0]          cfg_wdata
);

	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int DIV_SHIFT = 20;
	localparam int RECIP     = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int IW        = bscf_pkg::IDX_W;
	localparam int BW        = bscf_pkg::BIT_W;

	bscf_pkg::state_t    state_q, state_d;
	logic [5:0]          words_in_use_q;
	logic [AW-1:0]       clr_addr_q;
	logic                issued_all_q;
	logic                valid_s1;
	logic                out_valid_q;
	bscf_pkg::out_item_t out_data_q;

	logic [3:0]          req_q;
	logic [9:0]          pos_q;
	logic [10:0]         len_q;
	logic [IW-1:0]       quo_q;
	logic [5:0]          nw_q;
	logic [BW-1:0]       cap_q;
	logic [IW-1:0]       rem_q;
	logic [BW-1:0]       end_q;
	logic [AW-1:0]       scan_addr_q;
	logic [AW-1:0]       last_q;
	logic [BW-1:0]       base_q;
	logic                first_q;
	logic [AW-1:0]       addr_s1;
	logic [BW-1:0]       base_s1;
	logic                first_s1;
	logic [BW-1:0]       cnt_q;
	logic                all1_q;
	logic                all0_q;
	bscf_pkg::out_item_t res_q;

	logic [5:0]            nw_c;
	logic [31:0]           prod_c;
	logic [BW-1:0]         base_c;
	logic [IW-1:0]         rem_c;
	logic [BW-1:0]         sum_c;
	logic                  is_single;
	logic                  is_find;
	logic                  bad_c;
	logic                  unused_code;
	logic [BW-1:0]         avail_c;
	logic [IW-1:0]         lo_c;
	logic [BW-1:0]         cnt_next;
	logic                  all1_next;
	logic                  all0_next;
	logic                  scan_done;
	logic                  issue;
	logic                  out_free;
	bscf_pkg::out_item_t   res_c;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_BITS-1:0]  ram_wdata;
	logic [WORD_BITS-1:0]  ram_rdata;
	logic [WORD_BITS-1:0]  unit_wdata;
	bscf_pkg::word_flags_t flags;

	bscf_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (scan_addr_q),
		.rdata (ram_rdata)
	);

	bscf_word_unit #(
		.WORD_BITS (WORD_BITS)
	) u_word_unit (
		.req     (req_q),
		.rdata   (ram_rdata),
		.lo      (lo_c),
		.avail   (avail_c),
		.bit_sel (rem_q),
		.wdata   (unit_wdata),
		.flags   (flags)
	);

	always_comb begin
		if (words_in_use_q == 6'd0) begin
			nw_c = 6'd1;
		end else if (BW'(words_in_use_q) > BW'(NUM_WORDS)) begin
			nw_c = 6'(NUM_WORDS);
		end else begin
			nw_c = words_in_use_q;
		end
		prod_c    = 32'(pos_q) * 32'(RECIP);
		base_c    = BW'(quo_q) * BW'(WORD_BITS);
		rem_c     = IW'(BW'(pos_q) - base_c);
		sum_c     = BW'(pos_q) + BW'(len_q);
		is_single = (req_q == bscf_pkg::REQ_SET) || (req_q == bscf_pkg::REQ_CLEAR)
			|| (req_q == bscf_pkg::REQ_GET);
		is_find   = (req_q == bscf_pkg::REQ_FIND_SET) || (req_q == bscf_pkg::REQ_FIND_CLEAR);
		unused_code = req_q > bscf_pkg::REQ_FIND_CLEAR;
		bad_c     = BW'(pos_q) >= cap_q;
		avail_c   = (end_q > base_s1) ? (end_q - base_s1) : '0;
		lo_c      = (first_s1 && is_find) ? rem_q : '0;
		cnt_next  = cnt_q + BW'(flags.ones);
		all1_next = all1_q && flags.is_ones;
		all0_next = all0_q && flags.is_zero;
		scan_done = valid_s1 && ((addr_s1 == last_q) || (is_find && (flags.found
			|| (base_s1 + BW'(WORD_BITS) >= end_q))));
		issue     = (state_q == bscf_pkg::S_SCAN) && !issued_all_q && !scan_done;
		out_free  = !out_valid_q || out_ready;

		res_c.status = bscf_pkg::ST_OK;
		res_c.answer = '0;
		case (req_q)
			bscf_pkg::REQ_GET:       res_c.answer = bscf_pkg::ANS_W'(flags.bit_val);
			bscf_pkg::REQ_COUNT: begin
				res_c.answer = (cnt_next > BW'(bscf_pkg::ANS_MAX)) ? bscf_pkg::ANS_MAX
					: bscf_pkg::ANS_W'(cnt_next);
			end
			bscf_pkg::REQ_ALL_SET:   res_c.answer = bscf_pkg::ANS_W'(all1_next);
			bscf_pkg::REQ_ALL_CLEAR: res_c.answer = bscf_pkg::ANS_W'(all0_next);
			bscf_pkg::REQ_ANY_SET:   res_c.answer = bscf_pkg::ANS_W'(!all0_next);
			bscf_pkg::REQ_FIND_SET, bscf_pkg::REQ_FIND_CLEAR: begin
				if (flags.found) begin
					res_c.answer = bscf_pkg::ANS_W'(base_s1 + BW'(flags.first_idx));
				end else begin
					res_c.status = bscf_pkg::ST_NOTFOUND;
				end
			end
			default: res_c.answer = '0;
		endcase

		if (state_q == bscf_pkg::S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == bscf_pkg::S_SCAN) && valid_s1 && flags.write;
			ram_waddr = addr_s1;
			ram_wdata = unit_wdata;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bscf_pkg::S_CLEAR: begin
				if (clr_addr_q == AW'(NUM_WORDS - 1)) begin
					state_d = bscf_pkg::S_IDLE;
				end
			end
			bscf_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = bscf_pkg::S_DIV;
				end
			end
			bscf_pkg::S_DIV: state_d = bscf_pkg::S_REM;
			bscf_pkg::S_REM: begin
				if (unused_code || ((is_single || is_find) && bad_c)) begin
					state_d = bscf_pkg::S_DONE;
				end else begin
					state_d = bscf_pkg::S_SCAN;
				end
			end
			bscf_pkg::S_SCAN: begin
				if (scan_done) begin
					state_d = bscf_pkg::S_DONE;
				end
			end
			bscf_pkg::S_DONE: begin
				if (out_free) begin
					state_d = bscf_pkg::S_IDLE;
				end
			end
			default: state_d = bscf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bscf_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_in_use_q <= 6'd32;
			clr_addr_q     <= '0;
			issued_all_q   <= 1'b0;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				words_in_use_q <= cfg_wdata;
			end
			if (state_q == bscf_pkg::S_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (state_q == bscf_pkg::S_REM) begin
				issued_all_q <= 1'b0;
			end else if (issue && (scan_addr_q == last_q)) begin
				issued_all_q <= 1'b1;
			end
			valid_s1 <= issue;
			if ((state_q == bscf_pkg::S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data.req_type;
			pos_q <= in_data.position;
			len_q <= in_data.window_length;
		end
		if (state_q == bscf_pkg::S_DIV) begin
			quo_q <= IW'(prod_c >> DIV_SHIFT);
			nw_q  <= nw_c;
			cap_q <= BW'(nw_c) * BW'(WORD_BITS);
		end
		if (state_q == bscf_pkg::S_REM) begin
			rem_q       <= rem_c;
			end_q       <= (sum_c < cap_q) ? sum_c : cap_q;
			scan_addr_q <= (is_single || is_find) ? AW'(quo_q) : '0;
			last_q      <= is_single ? AW'(quo_q) : AW'(nw_q - 6'd1);
			base_q      <= (is_single || is_find) ? base_c : '0;
			first_q     <= 1'b1;
			cnt_q       <= '0;
			all1_q      <= 1'b1;
			all0_q      <= 1'b1;
			res_q.status <= ((is_single || is_find) && bad_c) ? bscf_pkg::ST_BADPOS
				: bscf_pkg::ST_OK;
			res_q.answer <= '0;
		end
		if (issue) begin
			scan_addr_q <= scan_addr_q + AW'(1);
			base_q      <= base_q + BW'(WORD_BITS);
			first_q     <= 1'b0;
		end
		addr_s1  <= scan_addr_q;
		base_s1  <= base_q;
		first_s1 <= first_q;
		if ((state_q == bscf_pkg::S_SCAN) && valid_s1) begin
			cnt_q  <= cnt_next;
			all1_q <= all1_next;
			all0_q <= all0_next;
		end
		if ((state_q == bscf_pkg::S_SCAN) && scan_done) begin
			res_q <= res_c;
		end
		if ((state_q == bscf_pkg::S_DONE) && out_free) begin
			out_data_q <= res_q;
		end
	end

	assign in_ready  = (state_q == bscf_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/core/bscf_ram.sv @@
module bscf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/bscf_word_unit.sv @@
module bscf_word_unit #(
	parameter int WORD_BITS = 32
) (
	input  logic [3:0]                  req,
	input  logic [WORD_BITS-1:0]        rdata,
	input  logic [bscf_pkg::IDX_W-1:0]  lo,
	input  logic [bscf_pkg::BIT_W-1:0]  avail,
	input  logic [bscf_pkg::IDX_W-1:0]  bit_sel,
	output logic [WORD_BITS-1:0]        wdata,
	output bscf_pkg::word_flags_t       flags
);

	localparam int SW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int LANES = (WORD_BITS + 7) / 8;

	logic [WORD_BITS-1:0] one_bit;
	logic [WORD_BITS-1:0] want_vec;
	logic [WORD_BITS-1:0] hits;
	logic [WORD_BITS-1:0] lowest;
	logic [LANES*8-1:0]   padded;
	logic [3:0]           lane_cnt [LANES];

	always_comb begin
		one_bit = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel[SW-1:0];

		flags.write = 1'b1;
		case (req)
			bscf_pkg::REQ_SET:       wdata = rdata | one_bit;
			bscf_pkg::REQ_CLEAR:     wdata = rdata & ~one_bit;
			bscf_pkg::REQ_SET_ALL:   wdata = '1;
			bscf_pkg::REQ_CLEAR_ALL: wdata = '0;
			bscf_pkg::REQ_INVERT:    wdata = ~rdata;
			default: begin
				wdata       = rdata;
				flags.write = 1'b0;
			end
		endcase

		want_vec = (req == bscf_pkg::REQ_FIND_CLEAR) ? ~rdata : rdata;
		for (int j = 0; j < WORD_BITS; j++) begin
			hits[j] = want_vec[j] && (bscf_pkg::IDX_W'(j) >= lo)
				&& (bscf_pkg::BIT_W'(j) < avail);
		end
		lowest = hits & (~hits + {{(WORD_BITS-1){1'b0}}, 1'b1});
		flags.found = |hits;
		flags.first_idx = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			flags.first_idx = flags.first_idx | (lowest[j] ? bscf_pkg::IDX_W'(j) : '0);
		end

		padded = (LANES*8)'(rdata);
		for (int l = 0; l < LANES; l++) begin
			lane_cnt[l] = '0;
			for (int b = 0; b < 8; b++) begin
				lane_cnt[l] = lane_cnt[l] + 4'(padded[l*8+b]);
			end
		end
		flags.ones = '0;
		for (int l = 0; l < LANES; l++) begin
			flags.ones = flags.ones + bscf_pkg::IDX_W'(lane_cnt[l]);
		end

		flags.is_ones = &rdata;
		flags.is_zero = ~|rdata;
		flags.bit_val = rdata[bit_sel[SW-1:0]];
	end

endmodule

@@ rtl/core/bscf_checker.sv @@
module bscf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input bscf_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == bscf_pkg::ST_OK)
			|| (out_data.status == bscf_pkg::ST_BADPOS)
			|| (out_data.status == bscf_pkg::ST_NOTFOUND))
		else $error("undefined status code");

	a_error_answer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != bscf_pkg::ST_OK) |-> out_data.answer == '0)
		else $error("non-zero answer with error status");

endmodule

bind bitmap_set_clear_count_find bscf_checker u_bscf_checker (.*);

@@ tb/bscf_check_pkg.sv @@
`timescale 1ns / 1ps

package bscf_check_pkg;

	import bscf_pkg::*;

	localparam int WBITS = 32;
	localparam int WORDS = 32;

	class bitmap_scoreboard;
		logic [WBITS-1:0] words [WORDS];
		logic [5:0]       words_in_use;
		out_item_t        expected_results [$];
		int               errors;

		function new();
			foreach (words[i])
				words[i] = '0;
			words_in_use = 6'd32;
			errors = 0;
		endfunction

		function void set_words_in_use(logic [5:0] value);
			words_in_use = value;
		endfunction

		// A setting of zero behaves as one word, anything above the array size as the whole array.
		function int capacity();
			int n;
			n = words_in_use;
			if (n < 1)
				n = 1;
			if (n > WORDS)
				n = WORDS;
			return n * WBITS;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void note_request(in_item_t item);
			int        cap;
			int        nw;
			int        pos;
			int        stop;
			int        cnt;
			logic      want;
			logic      all_ones;
			logic      all_zero;
			out_item_t exp;
			cap = capacity();
			nw = cap / WBITS;
			pos = item.position;
			exp.status = ST_OK;
			exp.answer = '0;
			case (item.req_type)
				REQ_SET, REQ_CLEAR, REQ_GET: begin
					if (pos >= cap)
						exp.status = ST_BADPOS;
					else if (item.req_type == REQ_SET)
						words[pos / WBITS][pos % WBITS] = 1'b1;
					else if (item.req_type == REQ_CLEAR)
						words[pos / WBITS][pos % WBITS] = 1'b0;
					else
						exp.answer = ANS_W'(words[pos / WBITS][pos % WBITS]);
				end
				REQ_SET_ALL, REQ_CLEAR_ALL, REQ_INVERT: begin
					for (int i = 0; i < nw; i++) begin
						if (item.req_type == REQ_SET_ALL)
							words[i] = '1;
						else if (item.req_type == REQ_CLEAR_ALL)
							words[i] = '0;
						else
							words[i] = ~words[i];
					end
				end
				REQ_COUNT: begin
					cnt = 0;
					for (int i = 0; i < nw; i++)
						cnt += $countones(words[i]);
					exp.answer = ANS_W'(cnt);
				end
				REQ_ALL_SET, REQ_ALL_CLEAR, REQ_ANY_SET: begin
					all_ones = 1'b1;
					all_zero = 1'b1;
					for (int i = 0; i < nw; i++) begin
						if (words[i] != '1)
							all_ones = 1'b0;
						if (words[i] != '0)
							all_zero = 1'b0;
					end
					if (item.req_type == REQ_ALL_SET)
						exp.answer = ANS_W'(all_ones);
					else if (item.req_type == REQ_ALL_CLEAR)
						exp.answer = ANS_W'(all_zero);
					else
						exp.answer = ANS_W'(!all_zero);
				end
				REQ_FIND_SET, REQ_FIND_CLEAR: begin
					if (pos >= cap) begin
						exp.status = ST_BADPOS;
					end else begin
						stop = pos + int'(item.window_length);
						if (stop > cap)
							stop = cap;
						want = (item.req_type == REQ_FIND_SET);
						exp.status = ST_NOTFOUND;
						for (int i = pos; i < stop; i++) begin
							if (words[i / WBITS][i % WBITS] == want) begin
								exp.status = ST_OK;
								exp.answer = ANS_W'(i);
								break;
							end
						end
					end
				end
				default: begin
				end
			endcase
			expected_results.push_back(exp);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d answer %0d",
					$time, got.status, got.answer);
				errors++;
				return;
			end
			exp = expected_results.pop_front();
			if (got.status !== exp.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d",
					$time, exp.status, got.status);
				errors++;
			end
			if (got.answer !== exp.answer) begin
				$display("%0t: answer mismatch, expected %0d, got %0d",
					$time, exp.answer, got.answer);
				errors++;
			end
		endfunction
	endclass

endpackage

@@ tb/bitmap_set_clear_count_find_test.sv @@
`timescale 1ns / 1ps

module bitmap_set_clear_count_find_test;

	import bscf_pkg::*;
	import bscf_check_pkg::*;

	localparam logic [3:0] REQ_UNUSED_LO = 4'd12;
	localparam logic [3:0] REQ_UNUSED_HI = 4'd15;
	localparam int         PHASE_ITEMS   = 150;
	localparam int         CYCLE_LIMIT   = 500000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_wen;
	logic [5:0]  cfg_wdata;

	bitmap_scoreboard sb;
	int cycle_count = 0;
	int ready_mode = 0;
	int ready_left = 0;

	bitmap_set_clear_count_find #(
		.WORD_BITS(WBITS),
		.NUM_WORDS(WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Every accepted transaction on either side is passed to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// The receiver switches between always ready, random stalls and long stalls.
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 2);
			ready_left <= $urandom_range(20, 200);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic send_request(input logic [3:0] req, input logic [9:0] pos,
		input logic [10:0] len);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{req_type: req, position: pos, window_length: len};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic pause(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic [5:0] value);
		drain();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		sb.set_words_in_use(value);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_directed();
		send_request(REQ_ALL_CLEAR, 10'd0, 11'd0);
		send_request(REQ_ANY_SET, 10'd0, 11'd0);
		send_request(REQ_FIND_SET, 10'd0, 11'd1024);
		send_request(REQ_SET, 10'd0, 11'd0);
		send_request(REQ_SET, 10'd1023, 11'd0);
		send_request(REQ_GET, 10'd1023, 11'd0);
		send_request(REQ_FIND_SET, 10'd1, 11'd2047);
		send_request(REQ_CLEAR, 10'd0, 11'd0);
		send_request(REQ_GET, 10'd0, 11'd0);
		send_request(REQ_FIND_CLEAR, 10'd0, 11'd0);
		send_request(REQ_COUNT, 10'd0, 11'd0);
		send_request(REQ_SET_ALL, 10'd0, 11'd0);
		send_request(REQ_ALL_SET, 10'd0, 11'd0);
		send_request(REQ_FIND_CLEAR, 10'd5, 11'd100);
		send_request(REQ_INVERT, 10'd0, 11'd0);
		send_request(REQ_ALL_CLEAR, 10'd0, 11'd0);
		send_request(REQ_UNUSED_LO, 10'd1023, 11'd2047);
		send_request(REQ_UNUSED_HI, 10'd1023, 11'd2047);
		configure(6'd1);
		send_request(REQ_SET, 10'd32, 11'd0);
		send_request(REQ_FIND_CLEAR, 10'd1023, 11'd1);
		send_request(REQ_SET_ALL, 10'd0, 11'd0);
		send_request(REQ_COUNT, 10'd0, 11'd0);
		configure(6'd63);
		send_request(REQ_COUNT, 10'd0, 11'd0);
		send_request(REQ_FIND_SET, 10'd31, 11'd2047);
		send_request(REQ_FIND_CLEAR, 10'd31, 11'd2);
	endtask

	task automatic run_random(input int count);
		int          burst_left;
		int          cap;
		int          r;
		logic [3:0]  req;
		logic [9:0]  pos;
		logic [10:0] len;
		burst_left = $urandom_range(1, 24);
		repeat (count) begin
			cap = sb.capacity();
			r = $urandom_range(0, 99);
			if (r < 30)
				req = REQ_SET;
			else if (r < 44)
				req = REQ_CLEAR;
			else if (r < 54)
				req = REQ_GET;
			else if (r < 57)
				req = REQ_SET_ALL;
			else if (r < 59)
				req = REQ_CLEAR_ALL;
			else if (r < 62)
				req = REQ_INVERT;
			else if (r < 67)
				req = REQ_COUNT;
			else if (r < 69)
				req = REQ_ALL_SET;
			else if (r < 71)
				req = REQ_ALL_CLEAR;
			else if (r < 73)
				req = REQ_ANY_SET;
			else if (r < 86)
				req = REQ_FIND_SET;
			else if (r < 98)
				req = REQ_FIND_CLEAR;
			else
				req = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
			if ($urandom_range(0, 6) != 0)
				pos = 10'($urandom_range(0, cap - 1));
			else
				pos = 10'($urandom_range(0, 1023));
			case ($urandom_range(0, 9))
				0: len = '0;
				1: len = '1;
				2, 3: len = 11'($urandom_range(0, 2047));
				4, 5: len = 11'($urandom_range(0, 1024));
				default: len = 11'($urandom_range(1, 40));
			endcase
			send_request(req, pos, len);
			if (burst_left == 0) begin
				pause($urandom_range(1, 40));
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		sb = new();
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random(PHASE_ITEMS);
		configure(6'd1);
		run_random(PHASE_ITEMS);
		configure(6'd0);
		run_random(PHASE_ITEMS);
		configure(6'd9);
		run_random(PHASE_ITEMS);
		configure(6'd33);
		run_random(PHASE_ITEMS);
		configure(6'd2);
		run_random(PHASE_ITEMS);
		configure(6'($urandom_range(0, 63)));
		run_random(PHASE_ITEMS);
		configure(6'd32);
		run_random(PHASE_ITEMS);
		drain();
		repeat (40)
			@(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
